/* hw/rtl/bai_pkg.sv */
// ----------------------------------------------------------------------------
// bai_pkg
// Shared types and constants for the blob autotile index resolver.
// ----------------------------------------------------------------------------
package bai_pkg;

  localparam int unsigned CASE_COUNT   = 47;
  localparam int unsigned MAX_VARIANTS = 256;

  localparam int unsigned CASE_W  = 6;
  localparam int unsigned VAR_W   = 8;
  localparam int unsigned SLOT_W  = 14;
  localparam int unsigned COUNT_W = 9;

  localparam logic [31:0] SEED_OFFSET   = 32'd907;
  localparam logic [31:0] HASH_MUL_X    = 32'd374761393;
  localparam logic [31:0] HASH_MUL_Y    = 32'd668265263;
  localparam logic [31:0] HASH_MUL_SEED = 32'd1442695041;
  localparam logic [31:0] HASH_MUL_MIX  = 32'd1274126177;
  localparam int unsigned HASH_SHIFT_A  = 13;
  localparam int unsigned HASH_SHIFT_B  = 16;

  typedef logic [1:0] cfg_index_t;
  localparam cfg_index_t CFG_WORLD_SEED    = 2'd0;
  localparam cfg_index_t CFG_VARIANT_TOTAL = 2'd1;

  // Classified item handed from front to back
  typedef struct packed {
    logic [CASE_W-1:0] case_idx;
    logic [31:0]       prod_x;
    logic [31:0]       prod_y;
  } bai_item_t;

  // Queue status seen by the top level
  typedef struct packed {
    logic full;
    logic empty;
  } bai_qstat_t;

endpackage

/* hw/rtl/blob_autotile_index_resolver.sv */
// ----------------------------------------------------------------------------
// blob_autotile_index_resolver
// Pipeline: the front register, the queue, two hash stages, eight remainder
//   stages of four bits each and the output register lie between the input
//   transaction and out_tvalid.
// Throughput: one transaction per cycle in both directions unless stalled.
// Reset: synchronous, active low; world_seed clears to 0, variant_total to 1,
//   all pipeline valids and the queue empty. No clearing pass.
// ----------------------------------------------------------------------------
module blob_autotile_index_resolver import bai_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input tile
  input  logic        in_tvalid,
  output logic        in_tready,
  // [0] occ_north, [1] occ_northeast, [2] occ_east, [3] occ_southeast,
  // [4] occ_south, [5] occ_southwest, [6] occ_west, [7] occ_northwest,
  // [39:8] tile_x, [71:40] tile_y
  input  logic [71:0] in_tdata,
  // Result
  output logic        out_tvalid,
  input  logic        out_tready,
  // [13:0] atlas_slot, [19:14] case_index, [27:20] variant_pick, [31:28] zero
  output logic [31:0] out_tdata,
  // Configuration writes
  input  logic        cfg_we,
  input  cfg_index_t  cfg_index,
  input  logic [31:0] cfg_wdata
);

  // Config: hold the seed already offset, and the variant count already
  // clamped to 1..MAX_VARIANTS so the back end divides by a legal value.
  logic [31:0]        seed_plus_r;
  logic [COUNT_W-1:0] var_count_r;
  logic [COUNT_W-1:0] var_total;
  logic [COUNT_W-1:0] var_count_nxt;

  assign var_total = cfg_wdata[COUNT_W-1:0];

  always_comb begin
    if (var_total == '0) begin
      var_count_nxt = COUNT_W'(1);
    end else if (var_total > COUNT_W'(MAX_VARIANTS)) begin
      var_count_nxt = COUNT_W'(MAX_VARIANTS);
    end else begin
      var_count_nxt = var_total;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_plus_r <= SEED_OFFSET;
      var_count_r <= COUNT_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WORLD_SEED:    seed_plus_r <= cfg_wdata + SEED_OFFSET;
        CFG_VARIANT_TOTAL: var_count_r <= var_count_nxt;
        default: ;  // drop writes to unknown registers
      endcase
    end
  end

  // Front: classify the tile and start the hash
  logic        item_valid;
  logic        item_ready;
  bai_item_t   item;
  logic [31:0] seed_term;

  bai_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .occ        (in_tdata[7:0]),
    .tile_x     (in_tdata[39:8]),
    .tile_y     (in_tdata[71:40]),
    .seed_plus  (seed_plus_r),
    .seed_term  (seed_term),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item)
  );

  // Queue: lets the front keep accepting while the back end stalls
  logic       q_valid;
  logic       q_ready;
  bai_item_t  q_data;
  bai_qstat_t q_stat;

  bai_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (item_valid),
    .push_ready (item_ready),
    .push_data  (item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data),
    .stat       (q_stat)
  );

  // Back: hash finish, modulo, slot
  logic [SLOT_W-1:0] atlas_slot;
  logic [CASE_W-1:0] case_index;
  logic [VAR_W-1:0]  variant_pick;

  bai_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .pop_valid    (q_valid),
    .pop_ready    (q_ready),
    .pop_data     (q_data),
    .seed_term    (seed_term),
    .var_count    (var_count_r),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .atlas_slot   (atlas_slot),
    .case_index   (case_index),
    .variant_pick (variant_pick)
  );

  assign out_tdata = {4'b0, variant_pick, case_index, atlas_slot};

  // Checks
  a_queue_status: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty together");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (var_count_r != '0) && (var_count_r <= COUNT_W'(MAX_VARIANTS)))
    else $error("variant count outside 1..MAX_VARIANTS");

  a_variant_below_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ({1'b0, variant_pick} < var_count_r))
    else $error("variant pick not below variant count");

  a_case_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (case_index <= CASE_W'(CASE_COUNT - 1)))
    else $error("case index beyond case count");

endmodule

/* hw/rtl/bai_front.sv */
// ----------------------------------------------------------------------------
// bai_front
// Accept a tile, rank its neighbor signature and start the coordinate hash.
// ----------------------------------------------------------------------------
module bai_front import bai_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        occ,
  input  logic [31:0]       tile_x,
  input  logic [31:0]       tile_y,
  input  logic [31:0]       seed_plus,
  output logic [31:0]       seed_term,
  output logic              item_valid,
  input  logic              item_ready,
  output bai_item_t         item
);

  // Rank of each reachable signature: edge count, then notch count, then code
  function automatic logic [CASE_W-1:0] case_of(input logic [7:0] sig);
    logic [CASE_W-1:0] c;
    case (sig)
      8'h00: c = 6'd0;
      8'h01: c = 6'd1;  8'h02: c = 6'd2;  8'h04: c = 6'd3;  8'h08: c = 6'd4;
      8'h03: c = 6'd5;  8'h05: c = 6'd6;  8'h06: c = 6'd7;  8'h09: c = 6'd8;
      8'h0A: c = 6'd9;  8'h0C: c = 6'd10;
      8'h07: c = 6'd11; 8'h0B: c = 6'd12; 8'h0D: c = 6'd13; 8'h0E: c = 6'd14;
      8'h0F: c = 6'd15;
      8'h10: c = 6'd16; 8'h20: c = 6'd17; 8'h40: c = 6'd18; 8'h80: c = 6'd19;
      8'h14: c = 6'd20; 8'h18: c = 6'd21; 8'h21: c = 6'd22; 8'h28: c = 6'd23;
      8'h41: c = 6'd24; 8'h42: c = 6'd25; 8'h82: c = 6'd26; 8'h84: c = 6'd27;
      8'h1C: c = 6'd28; 8'h29: c = 6'd29; 8'h43: c = 6'd30; 8'h86: c = 6'd31;
      8'h30: c = 6'd32; 8'h50: c = 6'd33; 8'h60: c = 6'd34; 8'h90: c = 6'd35;
      8'hA0: c = 6'd36; 8'hC0: c = 6'd37;
      8'h38: c = 6'd38; 8'h61: c = 6'd39; 8'h94: c = 6'd40; 8'hC2: c = 6'd41;
      8'h70: c = 6'd42; 8'hB0: c = 6'd43; 8'hD0: c = 6'd44; 8'hE0: c = 6'd45;
      8'hF0: c = 6'd46;
      default: c = '0;
    endcase
    return c;
  endfunction

  logic [7:0] sig;
  logic       valid_r;
  bai_item_t  item_r;
  logic [31:0] seed_term_r;

  // occ bit order: N, NE, E, SE, S, SW, W, NW
  always_comb begin
    sig[7] = ~occ[0];
    sig[6] = ~occ[2];
    sig[5] = ~occ[4];
    sig[4] = ~occ[6];
    sig[3] = occ[0] & occ[2] & ~occ[1];
    sig[2] = occ[4] & occ[2] & ~occ[3];
    sig[1] = occ[4] & occ[6] & ~occ[5];
    sig[0] = occ[0] & occ[6] & ~occ[7];
  end

  assign in_ready = !valid_r || item_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.case_idx <= case_of(sig);
      item_r.prod_x   <= tile_x * HASH_MUL_X;
      item_r.prod_y   <= tile_y * HASH_MUL_Y;
    end
  end

  // Seed product follows the config register in the next cycle
  always_ff @(posedge clk) begin
    seed_term_r <= seed_plus * HASH_MUL_SEED;
  end

  assign item_valid = valid_r;
  assign item       = item_r;
  assign seed_term  = seed_term_r;

endmodule

/* hw/rtl/bai_queue.sv */
// ----------------------------------------------------------------------------
// bai_queue
// Short FIFO between the front and back sections.
// ----------------------------------------------------------------------------
module bai_queue import bai_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_valid,
  output logic       push_ready,
  input  bai_item_t  push_data,
  output logic       pop_valid,
  input  logic       pop_ready,
  output bai_item_t  pop_data,
  output bai_qstat_t stat
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  bai_item_t   mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r;
  logic [AW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push;
  logic          do_pop;

  assign stat.full  = (count_r == CW'(DEPTH));
  assign stat.empty = (count_r == '0);
  assign push_ready = !stat.full;
  assign pop_valid  = !stat.empty;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_data   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* hw/rtl/bai_back.sv */
// ----------------------------------------------------------------------------
// bai_back
// Finish the coordinate hash, reduce it modulo the variant count over eight
// stages of four bits, and form the atlas slot.
// ----------------------------------------------------------------------------
module bai_back import bai_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  bai_item_t          pop_data,
  input  logic [31:0]        seed_term,
  input  logic [COUNT_W-1:0] var_count,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [SLOT_W-1:0]  atlas_slot,
  output logic [CASE_W-1:0]  case_index,
  output logic [VAR_W-1:0]   variant_pick
);

  localparam int unsigned DIV_STAGES = 8;
  localparam int unsigned DIV_BITS   = 32 / DIV_STAGES;

  typedef struct packed {
    logic [31:0]        hash;
    logic [COUNT_W-1:0] rem;
    logic [CASE_W-1:0]  case_idx;
  } div_stage_t;

  // Restoring remainder steps; rem stays below cnt, so one subtract per bit
  function automatic logic [COUNT_W-1:0] div_step(
    input logic [COUNT_W-1:0]  rem,
    input logic [DIV_BITS-1:0] bits,
    input logic [COUNT_W-1:0]  cnt
  );
    logic [COUNT_W:0]   t;
    logic [COUNT_W-1:0] r;
    r = rem;
    for (int j = DIV_BITS - 1; j >= 0; j--) begin
      t = {r, bits[j]};
      if (t >= {1'b0, cnt}) begin
        t = t - {1'b0, cnt};
      end
      r = t[COUNT_W-1:0];
    end
    return r;
  endfunction

  logic [31:0]       sum;
  logic              s1_v_r, s2_v_r, out_v_r;
  logic [31:0]       s1_hash_r, s2_hash_r;
  logic [CASE_W-1:0] s1_case_r, s2_case_r;
  logic              s1_rdy, s2_rdy, out_rdy;

  logic [DIV_STAGES-1:0] d_v_r;
  logic [DIV_STAGES-1:0] d_rdy;
  div_stage_t            d_r  [DIV_STAGES];
  div_stage_t            d_in [DIV_STAGES];
  logic [DIV_STAGES-1:0] d_in_v;

  logic [SLOT_W-1:0] slot_r;
  logic [CASE_W-1:0] case_r;
  logic [VAR_W-1:0]  var_r;

  // Ready chain, back to front
  assign out_rdy = !out_v_r || out_ready;
  assign d_rdy[DIV_STAGES-1] = !d_v_r[DIV_STAGES-1] || out_rdy;
  for (genvar i = 0; i < DIV_STAGES - 1; i++) begin : g_rdy
    assign d_rdy[i] = !d_v_r[i] || d_rdy[i+1];
  end
  assign s2_rdy    = !s2_v_r || d_rdy[0];
  assign s1_rdy    = !s1_v_r || s2_rdy;
  assign pop_ready = s1_rdy;

  // Stage 1: sum the three products, first xorshift
  assign sum = pop_data.prod_x + pop_data.prod_y + seed_term;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (s1_rdy) begin
        s1_v_r <= pop_valid;
      end
      if (s2_rdy) begin
        s2_v_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop_valid && s1_rdy) begin
      s1_hash_r <= sum ^ (sum >> HASH_SHIFT_A);
      s1_case_r <= pop_data.case_idx;
    end
    // Stage 2: mixing multiply
    if (s1_v_r && s2_rdy) begin
      s2_hash_r <= s1_hash_r * HASH_MUL_MIX;
      s2_case_r <= s1_case_r;
    end
  end

  // Division stages: the first takes the final xorshift and a zero remainder
  assign d_in[0].hash     = s2_hash_r ^ (s2_hash_r >> HASH_SHIFT_B);
  assign d_in[0].rem      = '0;
  assign d_in[0].case_idx = s2_case_r;
  assign d_in_v[0]        = s2_v_r;

  for (genvar i = 1; i < DIV_STAGES; i++) begin : g_link
    assign d_in[i] = d_r[i-1];
    assign d_in_v[i] = d_v_r[i-1];
  end

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        d_v_r[i] <= 1'b0;
      end else if (d_rdy[i]) begin
        d_v_r[i] <= d_in_v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (d_in_v[i] && d_rdy[i]) begin
        d_r[i].rem      <= div_step(d_in[i].rem, d_in[i].hash[31 -: DIV_BITS], var_count);
        d_r[i].hash     <= d_in[i].hash << DIV_BITS;
        d_r[i].case_idx <= d_in[i].case_idx;
      end
    end
  end

  // Output register: variant times case count plus case
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_rdy) begin
      out_v_r <= d_v_r[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (d_v_r[DIV_STAGES-1] && out_rdy) begin
      var_r  <= d_r[DIV_STAGES-1].rem[VAR_W-1:0];
      case_r <= d_r[DIV_STAGES-1].case_idx;
      slot_r <= SLOT_W'(d_r[DIV_STAGES-1].rem[VAR_W-1:0]) * SLOT_W'(CASE_COUNT)
              + SLOT_W'(d_r[DIV_STAGES-1].case_idx);
    end
  end

  assign out_valid    = out_v_r;
  assign atlas_slot   = slot_r;
  assign case_index   = case_r;
  assign variant_pick = var_r;

endmodule

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// Blob autotile index resolver testbench
// Streams tiles through the resolver and predicts each tile's atlas slot in
// software: the case rank comes from a signature table built at start-up, the
// variant from the coordinate hash. Each result transaction is checked field
// by field against the oldest prediction, under several seed and variant
// count settings and three idling patterns on both stream sides.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import bai_pkg::*;

  // Register indexes that decode to nothing; writes to them must be ignored
  localparam cfg_index_t CFG_SPARE_A = 2'd2;
  localparam cfg_index_t CFG_SPARE_B = 2'd3;

  localparam int unsigned DIRECTED_TILES = 22;
  localparam int unsigned PHASE_COUNT    = 8;
  localparam int unsigned PHASE_TILES    = 172;
  localparam int unsigned TOTAL_TILES    = DIRECTED_TILES + PHASE_COUNT * PHASE_TILES;
  localparam int unsigned SETTLE_CYCLES  = 24;
  // Cycles without any transaction before the run is declared hung
  localparam int unsigned STALL_LIMIT    = 4000;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [CASE_W-1:0] case_idx;
    logic [VAR_W-1:0]  pick;
  } tile_result_t;

  // --------------------------------------------------------------------------
  // Predicts atlas slots and holds them until the matching result arrives
  // --------------------------------------------------------------------------
  class tile_scoreboard;
    logic [31:0]        world_seed;
    logic [COUNT_W-1:0] variant_total;
    logic [CASE_W-1:0]  case_of_mask [256];
    tile_result_t       pending_slots [$];
    int                 errors;

    function new();
      bit          reachable [256];
      int unsigned rank;
      for (int s = 0; s < 256; s++) reachable[s] = 1'b0;
      for (int m = 0; m < 256; m++) reachable[edge_signature(8'(m))] = 1'b1;
      // Rank every reachable signature by edges, then notches, then value
      for (int m = 0; m < 256; m++) begin
        rank = 0;
        for (int s = 0; s < 256; s++)
          if (reachable[s] && order_key(8'(s)) < order_key(edge_signature(8'(m)))) rank++;
        case_of_mask[m] = CASE_W'(rank);
      end
      world_seed    = '0;
      variant_total = COUNT_W'(1);
      errors        = 0;
    endfunction

    // Open edges N/E/S/W on top, corner notches NE/SE/SW/NW below
    function logic [7:0] edge_signature(logic [7:0] m);
      return {~m[0], ~m[2], ~m[4], ~m[6],
              m[0] & m[2] & ~m[1], m[4] & m[2] & ~m[3],
              m[4] & m[6] & ~m[5], m[0] & m[6] & ~m[7]};
    endfunction

    function int unsigned order_key(logic [7:0] s);
      return ($countones(s[7:4]) << 12) | ($countones(s[3:0]) << 8) | s;
    endfunction

    function logic [31:0] coord_hash(logic [31:0] x, logic [31:0] y);
      logic [31:0] v;
      v = x * HASH_MUL_X + y * HASH_MUL_Y + (world_seed + SEED_OFFSET) * HASH_MUL_SEED;
      v = v ^ (v >> HASH_SHIFT_A);
      v = v * HASH_MUL_MIX;
      v = v ^ (v >> HASH_SHIFT_B);
      return v;
    endfunction

    function void write_reg(cfg_index_t idx, logic [31:0] d);
      case (idx)
        CFG_WORLD_SEED:    world_seed = d;
        CFG_VARIANT_TOTAL: variant_total = d[COUNT_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_tile(logic [71:0] d);
      tile_result_t r;
      logic [31:0]  count;
      // Zero acts as one variant; anything beyond the limit saturates
      if (variant_total == 0) count = 1;
      else if (variant_total > MAX_VARIANTS) count = MAX_VARIANTS;
      else count = 32'(variant_total);
      r.case_idx = case_of_mask[d[7:0]];
      r.pick     = VAR_W'(coord_hash(d[39:8], d[71:40]) % count);
      r.slot     = SLOT_W'(r.pick * CASE_COUNT + r.case_idx);
      pending_slots = {pending_slots, r};
    endfunction

    function void compare_field(string name, int unsigned expected, int unsigned actual);
      if (expected != actual) begin
        $display("%t: %s mismatch, expected %0d, actual %0d", $time, name, expected, actual);
        errors++;
      end
    endfunction

    function void check_result(logic [31:0] d);
      tile_result_t e;
      if (pending_slots.size() == 0) begin
        $display("%t: result %h with no tile outstanding", $time, d);
        errors++;
        return;
      end
      e = pending_slots.pop_front();
      compare_field("atlas_slot", 32'(e.slot), 32'(d[13:0]));
      compare_field("case_index", 32'(e.case_idx), 32'(d[19:14]));
      compare_field("variant_pick", 32'(e.pick), 32'(d[27:20]));
      compare_field("pad", 0, 32'(d[31:28]));
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  // [0] occ_north, [1] occ_northeast, [2] occ_east, [3] occ_southeast,
  // [4] occ_south, [5] occ_southwest, [6] occ_west, [7] occ_northwest,
  // [39:8] tile_x, [71:40] tile_y
  logic [71:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // [13:0] atlas_slot, [19:14] case_index, [27:20] variant_pick, [31:28] zero
  logic [31:0] out_tdata;
  logic        cfg_we     = 1'b0;
  cfg_index_t  cfg_index  = CFG_WORLD_SEED;
  logic [31:0] cfg_wdata  = '0;

  tile_scoreboard sb;
  int unsigned    tiles_sent   = 0;
  int unsigned    stall_cycles = 0;

  // Coordinate extremes: most negative, most positive, zero, minus one
  logic [31:0] coord_edge [4] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff};

  blob_autotile_index_resolver dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Idling pattern by progress: receiver-heavy stalls first, then sender-heavy
  // gaps, then a clean full-rate stretch.
  function automatic int unsigned send_idle_pct();
    if (tiles_sent < TOTAL_TILES / 3) return 34;
    else if (tiles_sent < 2 * TOTAL_TILES / 3) return 58;
    else return 0;
  endfunction

  function automatic int unsigned recv_idle_pct();
    if (tiles_sent < TOTAL_TILES / 3) return 58;
    else if (tiles_sent < 2 * TOTAL_TILES / 3) return 34;
    else return 0;
  endfunction

  // Drop out_tready at random; one assignment per edge.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct());
  end

  // Sample both handshakes with pre-edge values, feed the scoreboard, and
  // kill the run if the block stops moving.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_tile(in_tdata);
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we)
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles == STALL_LIMIT) begin
        $display("testbench: done, errors");
        $finish;
      end
    end
  end

  // Hold tvalid low for random gaps, then present the tile until accepted.
  task automatic send_tile(logic [71:0] d);
    while ($urandom_range(99) < send_idle_pct()) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tiles_sent++;
  endtask

  // Advance at least one edge, then hold until every predicted slot is in.
  task automatic wait_results_done();
    do @(posedge clk); while (sb.pending_slots.size() != 0);
  endtask

  // Drive one register write; the caller lowers cfg_we after the last one.
  task automatic write_reg(cfg_index_t idx, logic [31:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    sb.write_reg(idx, d);
    @(posedge clk);
  endtask

  function automatic logic [31:0] random_coord();
    case ($urandom_range(7))
      0:       return coord_edge[$urandom_range(3)];
      1:       return $urandom_range(255) - 128;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [31:0] seed;
    logic [31:0] total;
    logic [7:0]  mask;
    sb = new();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed tiles under reset settings: one neighbor present or missing
    // at a time, isolated and fully surrounded tiles, checkerboards, with
    // the coordinates walking through their extremes.
    for (int k = 0; k < DIRECTED_TILES; k++) begin
      if (k < 8) mask = 8'h01 << k;
      else if (k < 16) mask = ~(8'h01 << (k - 8));
      else if (k < 18) mask = (k == 16) ? 8'h55 : 8'haa;
      else mask = (k[0]) ? 8'hff : 8'h00;
      send_tile({coord_edge[(k / 4) % 4], coord_edge[k % 4], mask});
    end
    in_tvalid <= 1'b0;
    wait_results_done();

    // Each phase: reprogram while idle, stream random tiles, drain.
    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        0:       begin seed = 32'h8000_0000; total = 0;   end  // zero variants
        1:       begin seed = 32'h7fff_ffff; total = 256; end  // full variant range
        2:       begin seed = $urandom;      total = 32'hdead_be00 | 32'h1ff; end
        3:       begin seed = 32'hffff_ffff; total = 3;   end
        4:       begin seed = $urandom;      total = 257; end  // just past the limit
        5:       begin seed = $urandom;      total = $urandom_range(256, 1); end
        6:       begin seed = $urandom;      total = 2;   end
        default: begin seed = $urandom;      total = $urandom_range(511); end
      endcase
      write_reg(CFG_WORLD_SEED, seed);
      write_reg(CFG_VARIANT_TOTAL, total);
      if (p == 2) begin
        // Unmapped indexes must leave both registers untouched
        write_reg(CFG_SPARE_A, $urandom);
        write_reg(CFG_SPARE_B, $urandom);
      end
      cfg_we <= 1'b0;
      @(posedge clk);

      for (int k = 0; k < PHASE_TILES; k++) begin
        send_tile({random_coord(), random_coord(), 8'($urandom)});
        if (p == 3 && k == PHASE_TILES / 2) begin
          // Pause the sender mid-stream until the pipeline is empty
          in_tvalid <= 1'b0;
          wait_results_done();
        end
      end
      in_tvalid <= 1'b0;
      wait_results_done();
    end

    // Catch any stray result after the last expected one
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending_slots.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/bai_pkg.sv
hw/rtl/bai_front.sv
hw/rtl/bai_queue.sv
hw/rtl/bai_back.sv
hw/rtl/blob_autotile_index_resolver.sv
verif/testbench.sv
